// ----- src/psiva_pkg.sv -----
// Shared constants for the packed small-integer vector ALU.
// No dependencies; used by the top level and by its port checker.
`default_nettype none

package psiva_pkg;

   localparam int WORD_BITS          = 32;
   localparam int LANE_COUNT_DEFAULT = 4;
   localparam int LANE_BITS_DEFAULT  = 6;

   // request tdata: vec_a, vec_b, shift_amount, zero fill to whole bytes
   localparam int SHAMT_BITS    = 3;
   localparam int REQ_DATA_BITS = 72;
   localparam int MODE_BITS     = 2;

   localparam logic [MODE_BITS-1:0] MODE_ADD = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_SHL = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_SHR = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_SRA = 2'd3;

endpackage

`default_nettype wire

// ----- src/packed_small_int_vector_alu_top.sv -----
// Packed small-integer vector ALU: lane-wise add and shifts on a 32-bit word.
// Depends on psiva_pkg for word width, field layout and operation codes.
//
// Usage:
//   The req_ channel carries one request per handshake: the operation in
//   req_tuser, the two packed words and the shift distance in req_tdata.
//   Each request yields exactly one result word on the rsp_ channel, in order.
//   Lanes sit at the bottom of the word, one overflow flag per lane at the
//   top; the bits in between always read zero.
//   A request reaches rsp_tvalid through the input register, then the
//   result register. Throughput: one request per cycle while rsp_tready is
//   high, set by the single lane add/shift stage between the two registers.
//   The result register doubles as the output skid: a request is taken while
//   a finished result still waits, as long as the stage in front has room.
//   When rsp_tready is low, rsp_tdata holds; once both registers are full,
//   req_tready drops until the result is taken.
//   Reset (synchronous, active high) empties both registers; no result is
//   shown until a new request arrives.
`default_nettype none

module packed_small_int_vector_alu_top #(
   parameter int LANE_COUNT = psiva_pkg::LANE_COUNT_DEFAULT,
   parameter int LANE_BITS  = psiva_pkg::LANE_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [31:0] vec_a, [63:32] vec_b, [66:64] shift_amount, [71:67] zero
   input  wire logic [psiva_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // [1:0] mode
   input  wire logic [psiva_pkg::MODE_BITS-1:0]      req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [31:0] result_word
   output logic [psiva_pkg::WORD_BITS-1:0]           rsp_tdata
);

   localparam int WB = psiva_pkg::WORD_BITS;
   localparam int SB = psiva_pkg::SHAMT_BITS;

   logic                                s1_valid_ff, s1_valid_in;
   logic [psiva_pkg::MODE_BITS-1:0]     s1_mode_ff;
   logic [WB-1:0]                       s1_a_ff;
   logic [WB-1:0]                       s1_b_ff;
   logic [SB-1:0]                       s1_shamt_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [WB-1:0]                       rsp_data_ff, result_in;
   logic                                out_free, s1_move, req_take;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff  <= req_tuser;
         s1_a_ff     <= req_tdata[WB-1:0];
         s1_b_ff     <= req_tdata[2*WB-1:WB];
         s1_shamt_ff <= req_tdata[2*WB+SB-1:2*WB];
      end
      if (s1_move) begin
         rsp_data_ff <= result_in;
      end
   end

   // lane-wise operation; lanes are independent
   always_comb begin
      logic [LANE_BITS-1:0] lane_a;
      logic [LANE_BITS-1:0] lane_b;
      logic [LANE_BITS:0]   lane_sum;
      logic [LANE_BITS-1:0] lane_res;
      logic                 lane_flag;
      result_in = '0;
      for (int i = 0; i < LANE_COUNT; i++) begin
         lane_a    = s1_a_ff[i*LANE_BITS +: LANE_BITS];
         lane_b    = s1_b_ff[i*LANE_BITS +: LANE_BITS];
         lane_sum  = {lane_a[LANE_BITS-1], lane_a} + {lane_b[LANE_BITS-1], lane_b};
         lane_flag = 1'b0;
         case (s1_mode_ff)
            psiva_pkg::MODE_ADD: begin
               lane_res  = lane_sum[LANE_BITS-1:0];
               lane_flag = lane_sum[LANE_BITS] ^ lane_sum[LANE_BITS-1];
            end
            psiva_pkg::MODE_SHL: lane_res = lane_a << s1_shamt_ff;
            psiva_pkg::MODE_SHR: lane_res = lane_a >> s1_shamt_ff;
            psiva_pkg::MODE_SRA: lane_res = LANE_BITS'($signed(lane_a) >>> s1_shamt_ff);
            default:             lane_res = '0;
         endcase
         result_in[i*LANE_BITS +: LANE_BITS] = lane_res;
         result_in[WB-LANE_COUNT+i]          = lane_flag;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- src/psiva_checker.sv -----
// Port-level checks for the packed small-integer vector ALU, bound to the top.
// Depends on psiva_pkg and packed_small_int_vector_alu_top.
`default_nettype none

module psiva_checker #(
   parameter int LANE_COUNT = psiva_pkg::LANE_COUNT_DEFAULT,
   parameter int LANE_BITS  = psiva_pkg::LANE_BITS_DEFAULT
) (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_tvalid,
   input wire logic                                 req_tready,
   input wire logic [psiva_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input wire logic [psiva_pkg::MODE_BITS-1:0]      req_tuser,
   input wire logic                                 rsp_tvalid,
   input wire logic                                 rsp_tready,
   input wire logic [psiva_pkg::WORD_BITS-1:0]      rsp_tdata
);

   localparam logic [psiva_pkg::WORD_BITS-1:0] SPARE_MASK =
      ((32'h1 << (psiva_pkg::WORD_BITS - LANE_COUNT)) - 32'h1) &
      ~((32'h1 << (LANE_COUNT * LANE_BITS)) - 32'h1);

   logic req_take;
   assign req_take = req_tvalid && req_tready;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   // a taken request, with the receiver ready while it sits in the input register, shows up from the result register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $past(req_take, 2) && $past(rsp_tready, 1) && !$past(reset, 1)
         && !$past(reset, 2) |-> rsp_tvalid)
      else $error("result missing two cycles after request");

   a_spare_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata & SPARE_MASK) == '0)
      else $error("spare result bits not zero");

   a_no_req_data_x: assert property (@(posedge clock) disable iff (reset)
      req_take |-> !$isunknown({req_tuser, req_tdata}))
      else $error("request fields unknown");

endmodule

bind packed_small_int_vector_alu_top psiva_checker #(
   .LANE_COUNT (LANE_COUNT),
   .LANE_BITS  (LANE_BITS)
) u_psiva_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
